// ----- hw/rtl/kms_pkg.sv -----
// Shared types, constants and helper functions for the keypad matrix scanner.
package kms_pkg;

  // Matrix limits and fixed field widths
  localparam int MAX_ROWS   = 4;
  localparam int MAX_COLS   = 4;
  localparam int ROW_LIMIT  = (MAX_ROWS < 4) ? MAX_ROWS : 4;
  localparam int COL_LIMIT  = (MAX_COLS < 4) ? MAX_COLS : 4;
  localparam int NUM_LINES  = 4;
  localparam int CNT_W      = 3;
  localparam int ROW_W      = 2;
  localparam int COL_W      = 2;
  localparam int KEY_W      = NUM_LINES * NUM_LINES;
  localparam int IDX_W      = 4;
  localparam int CODE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS       = 3'd0,
    CFG_NUM_COLS       = 3'd1,
    CFG_DIODE_MODE     = 3'd2,
    CFG_KEYMAP_PRESENT = 3'd3,
    CFG_KEYMAP_LOW     = 3'd4,
    CFG_KEYMAP_HIGH    = 3'd5
  } kms_cfg_idx_t;

  // Effective configuration seen by the front and back ends
  typedef struct packed {
    logic [CNT_W-1:0]      rows;
    logic [CNT_W-1:0]      cols;
    logic                  diode;
    logic                  keymap_present;
    logic [CFG_DATA_W-1:0] keymap_low;
    logic [CFG_DATA_W-1:0] keymap_high;
  } kms_cfg_t;

  // One classified row sample, queued between front and back
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [ROW_W-1:0]     next_row;
    logic [NUM_LINES-1:0] mask;
    logic [NUM_LINES-1:0] chg;
    logic [NUM_LINES-1:0] now;
  } kms_job_t;

  // One result word
  typedef struct packed {
    logic [ROW_W-1:0]     drive_row;
    logic [NUM_LINES-1:0] drive_enable_mask;
    logic                 event_valid;
    logic                 event_pressed;
    logic [ROW_W-1:0]     event_row;
    logic [COL_W-1:0]     event_col;
    logic [CODE_W-1:0]    keycode;
    logic                 last;
  } kms_res_t;

  // Map a written count onto the range 1..limit
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input int limit);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(limit);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  // Look up a keycode byte for a key index
  function automatic logic [CODE_W-1:0] key_code(input kms_cfg_t cfg,
                                                 input logic [IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] word;
    word = idx[3] ? cfg.keymap_high : cfg.keymap_low;
    if (!cfg.keymap_present) begin
      return '0;
    end
    return word[{idx[2:0], 3'b000} +: CODE_W];
  endfunction

endpackage

// ----- hw/rtl/kms_front.sv -----
// Front end: accepts row samples, updates key state and queues change jobs.
module kms_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kms_pkg::kms_cfg_t               cfg,
  input  logic                            clear,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kms_pkg::NUM_LINES-1:0]   in_col_levels,
  input  logic                            q_full,
  output logic                            q_push,
  output kms_pkg::kms_job_t               q_job
);
  import kms_pkg::*;

  logic [KEY_W-1:0] keys_r, keys_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] row, next_row;
  logic [CNT_W-1:0] row_inc;
  logic [4:0]       base;
  logic [IDX_W-1:0] idx;
  logic             was, now;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Pick the sampled row and the next one to drive
  always_comb begin
    row      = ({1'b0, cur_row_r} >= cfg.rows) ? '0 : cur_row_r;
    row_inc  = {1'b0, row} + CNT_W'(1);
    next_row = (row_inc >= cfg.rows) ? '0 : row_inc[ROW_W-1:0];
    base     = 5'({3'b000, row} * {2'b00, cfg.cols});
  end

  // Classify each used column against the stored key state
  always_comb begin
    keys_nxt       = keys_r;
    q_job.row      = row;
    q_job.next_row = next_row;
    q_job.mask     = cfg.diode ? (NUM_LINES'(1) << next_row)
                               : NUM_LINES'((5'd1 << cfg.rows) - 5'd1);
    q_job.chg      = '0;
    q_job.now      = '0;
    idx            = '0;
    was            = 1'b0;
    now            = 1'b0;
    for (int c = 0; c < NUM_LINES; c++) begin
      idx = IDX_W'(base + 5'(c));
      was = keys_r[idx];
      now = !in_col_levels[c];
      if ((CNT_W'(c) < cfg.cols) && (now != was)) begin
        q_job.chg[c]  = 1'b1;
        q_job.now[c]  = now;
        keys_nxt[idx] = now;
      end
    end
    cur_row_nxt = next_row;
  end

  // Hold key state; drop it when the matrix shape changes
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      keys_r    <= '0;
      cur_row_r <= '0;
    end else if (accept) begin
      keys_r    <= keys_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

// ----- hw/rtl/kms_queue.sv -----
// Two-entry job queue between the front and back ends.
module kms_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kms_pkg::kms_job_t  push_job,
  input  logic               pop,
  output kms_pkg::kms_job_t  head,
  output logic               empty,
  output logic               full
);
  import kms_pkg::*;

  kms_job_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/kms_back.sv -----
// Back end: one result word per changed key of a job, or one with no event.
module kms_back (
  input  logic               clk,
  input  logic               rst_n,
  input  kms_pkg::kms_cfg_t  cfg,
  input  kms_pkg::kms_job_t  job,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output kms_pkg::kms_res_t  res
);
  import kms_pkg::*;

  logic [NUM_LINES-1:0] done_r, done_nxt;
  logic [NUM_LINES-1:0] rem, rest;
  logic [COL_W-1:0]     pick;
  logic                 has_evt, last, emit;
  logic                 out_valid_r;
  kms_res_t             res_r, res_nxt;
  logic [4:0]           base;
  logic [IDX_W-1:0]     idx;

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // Find the lowest column still to report
  always_comb begin
    rem  = job.chg & ~done_r;
    pick = '0;
    for (int c = NUM_LINES - 1; c >= 0; c--) begin
      if (rem[c]) begin
        pick = COL_W'(c);
      end
    end
    has_evt = (rem != '0);
    rest    = rem & ~(NUM_LINES'(1) << pick);
    last    = (rest == '0);
    emit    = !q_empty && (!out_valid_r || out_ready);
    q_pop   = emit && last;
    base    = 5'({3'b000, job.row} * {2'b00, cfg.cols});
    idx     = IDX_W'(base + {3'b000, pick});
  end

  // Build the next result word
  always_comb begin
    res_nxt.drive_row         = job.next_row;
    res_nxt.drive_enable_mask = job.mask;
    res_nxt.event_valid       = has_evt;
    res_nxt.event_pressed     = has_evt && job.now[pick];
    res_nxt.event_row         = has_evt ? job.row : '0;
    res_nxt.event_col         = has_evt ? pick : '0;
    res_nxt.keycode           = has_evt ? key_code(cfg, idx) : '0;
    res_nxt.last              = last;
    done_nxt                  = done_r;
    if (emit) begin
      done_nxt = last ? '0 : (done_r | (NUM_LINES'(1) << pick));
    end
  end

  // Hold the output word until taken; track reported columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      done_r <= done_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- hw/rtl/keypad_matrix_scanner.sv -----
// Top level of the keypad matrix scanner: config registers, front, queue, back.
//
// Each input word on in_* holds the active-low column levels sampled while the
// row last reported on out_drive_row was driven. The front end compares them
// with the stored pressed bits, updates that state at once and queues a job in
// a two-entry queue. The back end turns each job into one result word per
// changed key, in column order, or a single word with out_event_valid low when
// nothing changed; out_last marks the final word of an input word.
// An accepted word is queued as a job; the back end then registers each result
// word. Throughput: one result word per cycle while out_ready is high, so an
// input word yields 1 to 4 words as changed columns are reported one at a time.
// in_ready drops only while the queue holds two jobs; a stalled receiver holds
// the output register and fills the queue. cfg_ready is always high; writes to
// the row or column count clear all pressed bits and the row counter.
// Reset clears key state, the row counter, the queue and restores defaults:
// four rows, four columns, diode mode off, keymap absent and zero.
module keypad_matrix_scanner (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kms_pkg::NUM_LINES-1:0]     in_col_levels,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kms_pkg::ROW_W-1:0]         out_drive_row,
  output logic [kms_pkg::NUM_LINES-1:0]     out_drive_enable_mask,
  output logic                              out_event_valid,
  output logic                              out_event_pressed,
  output logic [kms_pkg::ROW_W-1:0]         out_event_row,
  output logic [kms_pkg::COL_W-1:0]         out_event_col,
  output logic [kms_pkg::CODE_W-1:0]        out_keycode,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kms_pkg::*;

  logic [CNT_W-1:0]      num_rows_r, num_cols_r;
  logic                  diode_r, keymap_present_r;
  logic [CFG_DATA_W-1:0] keymap_low_r, keymap_high_r;
  logic                  cfg_wr, clear;
  kms_cfg_t              cfg;
  kms_job_t              push_job, head_job;
  logic                  q_push, q_pop, q_empty, q_full;
  kms_res_t              res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clear     = cfg_wr && ((cfg_index == CFG_NUM_ROWS) || (cfg_index == CFG_NUM_COLS));

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r       <= CNT_W'(4);
      num_cols_r       <= CNT_W'(4);
      diode_r          <= 1'b0;
      keymap_present_r <= 1'b0;
      keymap_low_r     <= '0;
      keymap_high_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_NUM_ROWS:       num_rows_r       <= cfg_data[CNT_W-1:0];
        CFG_NUM_COLS:       num_cols_r       <= cfg_data[CNT_W-1:0];
        CFG_DIODE_MODE:     diode_r          <= cfg_data[0];
        CFG_KEYMAP_PRESENT: keymap_present_r <= cfg_data[0];
        CFG_KEYMAP_LOW:     keymap_low_r     <= cfg_data;
        CFG_KEYMAP_HIGH:    keymap_high_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp counts into the usable range
  always_comb begin
    cfg.rows           = clamp_count(num_rows_r, ROW_LIMIT);
    cfg.cols           = clamp_count(num_cols_r, COL_LIMIT);
    cfg.diode          = diode_r;
    cfg.keymap_present = keymap_present_r;
    cfg.keymap_low     = keymap_low_r;
    cfg.keymap_high    = keymap_high_r;
  end

  kms_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .clear         (clear),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_col_levels (in_col_levels),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  kms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  kms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job       (head_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_drive_row         = res.drive_row;
  assign out_drive_enable_mask = res.drive_enable_mask;
  assign out_event_valid       = res.event_valid;
  assign out_event_pressed     = res.event_pressed;
  assign out_event_row         = res.event_row;
  assign out_event_col         = res.event_col;
  assign out_keycode           = res.keycode;
  assign out_last              = res.last;

  // A word without a key change always closes its input word
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> out_last)
    else $error("result without event is not last");

  // Some row is always driven
  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_enable_mask != '0)
    else $error("no row driven");

  // In diode mode only the selected row is driven
  a_diode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && diode_r |-> $onehot(out_drive_enable_mask))
    else $error("diode mode drives more than one row");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the keypad matrix scanner: row samples checked against an in-bench scan predictor.
module tb_top;
  import kms_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 40;
  localparam int MAX_WAIT      = 8;

  typedef struct {
    logic [NUM_LINES-1:0] levels;
    int unsigned          gap;
  } scan_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [NUM_LINES-1:0]  in_col_levels = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROW_W-1:0]      out_drive_row;
  logic [NUM_LINES-1:0]  out_drive_enable_mask;
  logic                  out_event_valid;
  logic                  out_event_pressed;
  logic [ROW_W-1:0]      out_event_row;
  logic [COL_W-1:0]      out_event_col;
  logic [CODE_W-1:0]     out_keycode;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keypad_matrix_scanner dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_col_levels         (in_col_levels),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_drive_row         (out_drive_row),
    .out_drive_enable_mask (out_drive_enable_mask),
    .out_event_valid       (out_event_valid),
    .out_event_pressed     (out_event_pressed),
    .out_event_row         (out_event_row),
    .out_event_col         (out_event_col),
    .out_keycode           (out_keycode),
    .out_last              (out_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #10 clk = ~clk;

  // Scan predictor state: register copy, held keys, row counter
  logic [CNT_W-1:0]      cur_rows;
  logic [CNT_W-1:0]      cur_cols;
  logic                  cur_diode;
  logic                  cur_keymap_on;
  logic [CFG_DATA_W-1:0] cur_map_lo;
  logic [CFG_DATA_W-1:0] cur_map_hi;
  logic [KEY_W-1:0]      held_keys;
  logic [ROW_W-1:0]      scan_row;

  kms_res_t    expected_words[$];
  scan_word_t  pending_scans[$];
  kms_res_t    want_word;

  int unsigned mismatches = 0;
  int unsigned scans_taken = 0;
  int unsigned words_seen = 0;
  int unsigned events_seen = 0;
  int unsigned settings_run = 0;
  int unsigned gap_max = 0;

  // Map a register count onto the range actually scanned
  function automatic int unsigned eff_count(input logic [CNT_W-1:0] v, input int unsigned limit);
    int unsigned lim;
    lim = (limit > 4) ? 4 : limit;
    if (lim < 1) lim = 1;
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // Compare one row sample with the held keys and queue the event words it causes
  function automatic void predict_scan(input logic [NUM_LINES-1:0] levels);
    int unsigned rows, cols, row, nxt, idx;
    logic [NUM_LINES-1:0] mask;
    logic now;
    logic [CFG_DATA_W-1:0] mapw;
    kms_res_t w;
    kms_res_t batch[$];
    rows = eff_count(cur_rows, MAX_ROWS);
    cols = eff_count(cur_cols, MAX_COLS);
    row = 32'(scan_row);
    if (row >= rows) row = 0;
    nxt = (row + 1 >= rows) ? 0 : row + 1;
    mask = cur_diode ? NUM_LINES'(1 << nxt) : NUM_LINES'((1 << rows) - 1);
    for (int c = 0; c < cols; c++) begin
      idx = row * cols + c;
      now = ~levels[c];
      if (now != held_keys[idx]) begin
        w = '0;
        w.event_valid = 1'b1;
        w.event_pressed = now;
        w.event_row = ROW_W'(row);
        w.event_col = COL_W'(c);
        if (cur_keymap_on) begin
          mapw = (idx < 8) ? cur_map_lo : cur_map_hi;
          w.keycode = mapw[(idx % 8) * 8 +: CODE_W];
        end
        held_keys[idx] = now;
        batch = {batch, w};
      end
    end
    // no change still gives one word without an event
    if (batch.size() == 0) begin
      w = '0;
      batch = {batch, w};
    end
    foreach (batch[k]) begin
      batch[k].drive_row = ROW_W'(nxt);
      batch[k].drive_enable_mask = mask;
      batch[k].last = (k == batch.size() - 1);
      expected_words = {expected_words, batch[k]};
    end
    scan_row = ROW_W'(nxt);
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_NUM_ROWS: begin
        cur_rows = data[CNT_W-1:0];
        held_keys = '0;
        scan_row = '0;
      end
      CFG_NUM_COLS: begin
        cur_cols = data[CNT_W-1:0];
        held_keys = '0;
        scan_row = '0;
      end
      CFG_DIODE_MODE:     cur_diode = data[0];
      CFG_KEYMAP_PRESENT: cur_keymap_on = data[0];
      CFG_KEYMAP_LOW:     cur_map_lo = data;
      CFG_KEYMAP_HIGH:    cur_map_hi = data;
      default: ;
    endcase
  endfunction

  // Random bits above a narrow register value
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] v,
                                                       input int unsigned width);
    logic [CFG_DATA_W-1:0] r;
    r = {$urandom, $urandom};
    r = (r >> width) << width;
    return r | v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (result %0d)", name, got, want, words_seen));
  endtask

  // Input side: record accepted words and predict at the accepting edge
  logic in_fire = 1'b0;
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      predict_scan(in_col_levels);
      scans_taken++;
    end
  end

  // Driver: wait out each word's gap, then hold it until accepted
  logic       drv_busy = 1'b0;
  scan_word_t drv_word;
  always @(negedge clk) begin
    if (drv_busy && in_fire) drv_busy = 1'b0;
    if (!drv_busy && rst_n && pending_scans.size() != 0) begin
      if (pending_scans[0].gap > 0) begin
        pending_scans[0].gap = pending_scans[0].gap - 1;
      end else begin
        drv_word = pending_scans.pop_front();
        drv_busy = 1'b1;
      end
    end
    in_valid <= drv_busy;
    if (drv_busy) in_col_levels <= drv_word.levels;
  end

  // Monitor: check each accepted result word against the oldest expectation
  logic out_fire = 1'b0;
  always @(posedge clk) begin
    out_fire = rst_n && out_valid && out_ready;
    if (out_fire) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", words_seen));
      end else begin
        want_word = expected_words.pop_front();
        check_field("drive_row", 64'(out_drive_row), 64'(want_word.drive_row));
        check_field("drive_enable_mask", 64'(out_drive_enable_mask),
                    64'(want_word.drive_enable_mask));
        check_field("event_valid", 64'(out_event_valid), 64'(want_word.event_valid));
        check_field("event_pressed", 64'(out_event_pressed), 64'(want_word.event_pressed));
        check_field("event_row", 64'(out_event_row), 64'(want_word.event_row));
        check_field("event_col", 64'(out_event_col), 64'(want_word.event_col));
        check_field("keycode", 64'(out_keycode), 64'(want_word.keycode));
        check_field("last", 64'(out_last), 64'(want_word.last));
      end
      words_seen++;
      if (out_event_valid === 1'b1) events_seen++;
    end
  end

  // Receiver: random stall after each word, plus a long hold-off on request
  int unsigned hold_ask = 0;
  int unsigned hold_left = 0;
  int unsigned rx_wait = 0;
  logic        rx_calm = 1'b0;
  always @(negedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (out_fire) rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
  endtask

  task automatic cfg_release;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_scan(input logic [NUM_LINES-1:0] levels);
    scan_word_t s;
    s.levels = levels;
    s.gap = $urandom_range(0, gap_max);
    pending_scans = {pending_scans, s};
  endtask

  // Wait until every word is sent and answered, then let the pipeline settle
  task automatic drain;
    while (pending_scans.size() != 0 || drv_busy || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_run++;
  endtask

  // One random setting: mostly held or slightly changed rows, some full noise
  task automatic random_phase(input int unsigned n_scans, input logic [CNT_W-1:0] rows,
                              input logic [CNT_W-1:0] cols, input int unsigned hold);
    int unsigned rr, row;
    logic [NUM_LINES-1:0] lv;
    logic [NUM_LINES-1:0] prev [4];
    cfg_write(CFG_NUM_ROWS, with_noise(64'(rows), CNT_W));
    cfg_write(CFG_NUM_COLS, with_noise(64'(cols), CNT_W));
    cfg_write(CFG_DIODE_MODE, with_noise(64'($urandom_range(0, 1)), 1));
    cfg_write(CFG_KEYMAP_PRESENT, with_noise(64'($urandom_range(0, 1)), 1));
    cfg_write(CFG_KEYMAP_LOW, {$urandom, $urandom});
    cfg_write(CFG_KEYMAP_HIGH, {$urandom, $urandom});
    cfg_release();
    hold_ask = hold;
    rr = eff_count(rows, MAX_ROWS);
    row = 0;
    for (int r = 0; r < 4; r++) prev[r] = '1;
    for (int i = 0; i < n_scans; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: lv = prev[row];
        3, 4, 5, 6: lv = prev[row] ^ NUM_LINES'(1 << $urandom_range(0, NUM_LINES - 1));
        7, 8: lv = NUM_LINES'($urandom);
        default: lv = $urandom_range(0, 1) ? '0 : '1;
      endcase
      prev[row] = lv;
      queue_scan(lv);
      row = (row + 1) % rr;
    end
    drain();
  endtask

  initial begin
    cur_rows = CNT_W'(4);
    cur_cols = CNT_W'(4);
    cur_diode = 1'b0;
    cur_keymap_on = 1'b0;
    cur_map_lo = '0;
    cur_map_hi = '0;
    held_keys = '0;
    scan_row = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: press every key row by row, then release and mix
    gap_max = MAX_WAIT;
    queue_scan(4'hF);
    repeat (5) queue_scan(4'h0);
    queue_scan(4'hF);
    queue_scan(4'hA);
    queue_scan(4'h5);
    drain();

    // Keymap lookup and diode drive, with writes to unused indexes ignored
    cfg_write(CFG_KEYMAP_LOW, {$urandom, $urandom});
    cfg_write(CFG_KEYMAP_HIGH, {$urandom, $urandom});
    cfg_write(CFG_KEYMAP_PRESENT, 64'd1);
    cfg_write(CFG_DIODE_MODE, 64'd1);
    cfg_write(CFG_SPARE_LO, '1);
    cfg_write(CFG_SPARE_HI, {$urandom, $urandom});
    cfg_release();
    repeat (4) queue_scan(4'h0);
    repeat (4) queue_scan(4'hF);
    drain();

    // Zero rows read as one, too many columns clamp to the limit
    cfg_write(CFG_NUM_ROWS, 64'd0);
    cfg_write(CFG_NUM_COLS, 64'd7);
    cfg_write(CFG_DIODE_MODE, 64'd0);
    cfg_release();
    queue_scan(4'h0);
    queue_scan(4'hF);
    queue_scan(4'h6);
    drain();

    // Too many rows clamp, one column: upper level bits are ignored
    cfg_write(CFG_NUM_ROWS, 64'd7);
    cfg_write(CFG_NUM_COLS, 64'd1);
    cfg_write(CFG_DIODE_MODE, 64'd1);
    cfg_release();
    queue_scan(4'hE);
    queue_scan(4'h1);
    queue_scan(4'hF);
    queue_scan(4'h0);
    queue_scan(4'hE);
    drain();

    // Random settings, the extremes among them
    random_phase(14, CNT_W'(4), CNT_W'(4), 0);
    random_phase(14, CNT_W'(1), CNT_W'(1), 0);
    random_phase(14, CNT_W'($urandom_range(0, 7)), CNT_W'($urandom_range(0, 7)), 0);

    // Back-pressure: receiver holds off while the sender keeps offering
    gap_max = 0;
    random_phase(14, CNT_W'(4), CNT_W'(4), 80);

    // No idling on either side
    rx_calm = 1'b1;
    random_phase(14, CNT_W'($urandom_range(0, 7)), CNT_W'($urandom_range(0, 7)), 0);
    rx_calm = 1'b0;
    gap_max = MAX_WAIT;
    random_phase(14, CNT_W'($urandom_range(0, 7)), CNT_W'($urandom_range(0, 7)), 0);

    $display("Covered %0d row samples and %0d result words (%0d key events) over %0d settings.",
             scans_taken, words_seen, events_seen, settings_run);
    $display("Mismatches counted: %0d", mismatches);
    if (mismatches == 0) begin
      $display("keypad_matrix_scanner regression: pass");
    end else begin
      $display("keypad_matrix_scanner regression: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #4_000_000;
    $display("keypad_matrix_scanner regression: fail");
    $finish;
  end

endmodule

// ----- keypad_matrix_scanner.f -----
hw/rtl/kms_pkg.sv
hw/rtl/kms_front.sv
hw/rtl/kms_queue.sv
hw/rtl/kms_back.sv
hw/rtl/keypad_matrix_scanner.sv
tb/tb_top.sv
